[design/sidec_pkg.sv]
package sidec_pkg;

  // ASCII output codes, 6 bits wide
  localparam int unsigned CharW = 6;
  localparam logic [CharW-1:0] CharZero  = 6'd48;
  localparam logic [CharW-1:0] CharMinus = 6'd45;

  // Shift-and-add-3 steps done in one pipeline stage
  localparam int unsigned StepsPerStage = 8;

  typedef logic [3:0] bcd_digit_t;

  // Decimal digits needed for a magnitude of the given bit count:
  // floor(width * log10(2)) + 1, with log10(2) ~ 1233 / 4096.
  function automatic int unsigned num_digits(input int unsigned width);
    return ((width * 1233) >> 12) + 1;
  endfunction

endpackage

[design/sidec_front.sv]
module sidec_front #(
  parameter int unsigned ValueW = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] in_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_neg_o,
  output logic [ValueW-1:0] out_mag_o
);

  logic              valid_q;
  logic              neg_q, neg_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic              load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Split sign and unsigned magnitude; the most negative value maps to 2^(W-1)
  always_comb begin
    neg_d = in_value_i[ValueW-1];
    mag_d = neg_d ? ValueW'(~in_value_i + 1'b1) : in_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q <= neg_d;
      mag_q <= mag_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_neg_o   = neg_q;
  assign out_mag_o   = mag_q;

endmodule

[design/sidec_dabble_stage.sv]
module sidec_dabble_stage #(
  parameter int unsigned ValueW    = 32,
  parameter int unsigned NumDigits = 10,
  parameter int unsigned Steps     = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_neg_i,
  input  logic [ValueW-1:0]      in_mag_i,
  input  logic [4*NumDigits-1:0] in_bcd_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_neg_o,
  output logic [ValueW-1:0]      out_mag_o,
  output logic [4*NumDigits-1:0] out_bcd_o
);

  import sidec_pkg::*;

  localparam int unsigned BcdW = 4 * NumDigits;

  logic            valid_q;
  logic            neg_q;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic            load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Run this stage's share of shift-and-add-3 steps, MSB of the magnitude first
  always_comb begin
    bcd_digit_t dig;
    mag_d = in_mag_i;
    bcd_d = in_bcd_i;
    for (int s = 0; s < Steps; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        dig = bcd_d[4*d +: 4];
        if (dig >= 4'd5) begin
          bcd_d[4*d +: 4] = dig + 4'd3;
        end
      end
      bcd_d = {bcd_d[BcdW-2:0], mag_d[ValueW-1]};
      mag_d = {mag_d[ValueW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q <= in_neg_i;
      mag_q <= mag_d;
      bcd_q <= bcd_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_neg_o   = neg_q;
  assign out_mag_o   = mag_q;
  assign out_bcd_o   = bcd_q;

endmodule

[design/sidec_lead.sv]
module sidec_lead #(
  parameter int unsigned NumDigits = 10,
  parameter int unsigned IdxW      = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_neg_i,
  input  logic [4*NumDigits-1:0] in_bcd_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_neg_o,
  output logic [4*NumDigits-1:0] out_bcd_o,
  output logic [IdxW-1:0]        out_nsig_o
);

  logic                   valid_q;
  logic                   neg_q;
  logic [4*NumDigits-1:0] bcd_q;
  logic [IdxW-1:0]        nsig_q, nsig_d;
  logic                   load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Count significant digits; zero still prints one digit
  always_comb begin
    nsig_d = IdxW'(1);
    for (int d = 0; d < NumDigits; d++) begin
      if (in_bcd_i[4*d +: 4] != 4'd0) begin
        nsig_d = IdxW'(d + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q  <= in_neg_i;
      bcd_q  <= in_bcd_i;
      nsig_q <= nsig_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_neg_o   = neg_q;
  assign out_bcd_o   = bcd_q;
  assign out_nsig_o  = nsig_q;

endmodule

[design/sidec_serializer.sv]
module sidec_serializer #(
  parameter int unsigned NumDigits = 10,
  parameter int unsigned IdxW      = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_neg_i,
  input  logic [4*NumDigits-1:0]       in_bcd_i,
  input  logic [IdxW-1:0]              in_nsig_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sidec_pkg::CharW-1:0]  out_char_o,
  output logic                         out_last_o
);

  import sidec_pkg::*;

  localparam int unsigned DigIdxW = $clog2(NumDigits);

  // Work registers: the item being printed
  logic                   w_valid_q;
  logic                   w_neg_q;
  logic [IdxW-1:0]        w_idx_q;
  logic [4*NumDigits-1:0] w_bcd_q;

  // Output register
  logic             o_valid_q;
  logic [CharW-1:0] o_char_q, o_char_d;
  logic             o_last_q, o_last_d;

  logic             out_free, emit, emit_last, load;
  logic [IdxW-1:0]  sel;
  bcd_digit_t       digit;
  bcd_digit_t       digs [NumDigits];

  assign out_free  = !o_valid_q || out_ready_i;
  assign emit      = w_valid_q && out_free;
  assign emit_last = !w_neg_q && (w_idx_q == IdxW'(1));

  assign in_ready_o = !w_valid_q || (out_free && emit_last);
  assign load       = in_valid_i && in_ready_o;

  // Pick the next character: minus sign first, then digits MSB first
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      digs[d] = w_bcd_q[4*d +: 4];
    end
    sel   = w_idx_q - IdxW'(1);
    digit = digs[sel[DigIdxW-1:0]];
    if (w_neg_q) begin
      o_char_d = CharMinus;
      o_last_d = 1'b0;
    end else begin
      o_char_d = CharZero + CharW'(digit);
      o_last_d = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (load) begin
        w_valid_q <= 1'b1;
      end else if (emit && emit_last) begin
        w_valid_q <= 1'b0;
      end
      if (out_free) begin
        o_valid_q <= w_valid_q;
      end
    end
  end

  // Load a new item or advance through the current one
  always_ff @(posedge clk_i) begin
    if (load) begin
      w_neg_q <= in_neg_i;
      w_idx_q <= in_nsig_i;
      w_bcd_q <= in_bcd_i;
    end else if (emit) begin
      if (w_neg_q) begin
        w_neg_q <= 1'b0;
      end else begin
        w_idx_q <= sel;
      end
    end
    if (emit) begin
      o_char_q <= o_char_d;
      o_last_q <= o_last_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_char_o  = o_char_q;
  assign out_last_o  = o_last_q;

endmodule

[design/signed_int_to_decimal_ascii_unit.sv]
// Converts one signed VALUE_WIDTH-bit integer per input transfer into its
// decimal ASCII text, one character per output transfer: a minus sign for
// negative values, then the digits most significant first with leading zeros
// dropped (zero prints "0"); last_o marks the final character. The most
// negative value prints correctly. Conversion runs in a pipeline of a
// sign/magnitude stage, ceil(VALUE_WIDTH/8) shift-and-add-3 stages of up to
// eight bits each, a digit-count stage and the character serializer.
// The serializer sets the rate: it sends one character per cycle while
// out_ready_i is high, and an item is (digits + sign) characters, 1 to 11
// for a 32-bit value; the pipeline ahead of it holds further items meanwhile.
module signed_int_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [VALUE_WIDTH-1:0]      value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sidec_pkg::CharW-1:0] char_code_o,
  output logic                        last_o
);

  import sidec_pkg::*;

  localparam int unsigned NumDigits = num_digits(VALUE_WIDTH);
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned IdxW      = $clog2(NumDigits + 1);
  localparam int unsigned NStages   = (VALUE_WIDTH + StepsPerStage - 1) / StepsPerStage;

  logic                   st_valid [NStages+1];
  logic                   st_ready [NStages+1];
  logic                   st_neg   [NStages+1];
  logic [VALUE_WIDTH-1:0] st_mag   [NStages+1];
  logic [BcdW-1:0]        st_bcd   [NStages+1];

  logic                   ld_valid, ld_ready, ld_neg;
  logic [BcdW-1:0]        ld_bcd;
  logic [IdxW-1:0]        ld_nsig;

  // Sign and magnitude
  sidec_front #(
    .ValueW (VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_value_i  (value_i),
    .out_valid_o (st_valid[0]),
    .out_ready_i (st_ready[0]),
    .out_neg_o   (st_neg[0]),
    .out_mag_o   (st_mag[0])
  );

  assign st_bcd[0] = '0;

  // Binary to BCD conversion stages
  for (genvar s = 0; s < NStages; s++) begin : g_dabble
    localparam int unsigned Steps = (s == NStages - 1) ?
        VALUE_WIDTH - StepsPerStage * (NStages - 1) : StepsPerStage;

    sidec_dabble_stage #(
      .ValueW    (VALUE_WIDTH),
      .NumDigits (NumDigits),
      .Steps     (Steps)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_valid[s]),
      .in_ready_o  (st_ready[s]),
      .in_neg_i    (st_neg[s]),
      .in_mag_i    (st_mag[s]),
      .in_bcd_i    (st_bcd[s]),
      .out_valid_o (st_valid[s+1]),
      .out_ready_i (st_ready[s+1]),
      .out_neg_o   (st_neg[s+1]),
      .out_mag_o   (st_mag[s+1]),
      .out_bcd_o   (st_bcd[s+1])
    );
  end

  // Count significant digits
  sidec_lead #(
    .NumDigits (NumDigits),
    .IdxW      (IdxW)
  ) u_lead (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (st_valid[NStages]),
    .in_ready_o  (st_ready[NStages]),
    .in_neg_i    (st_neg[NStages]),
    .in_bcd_i    (st_bcd[NStages]),
    .out_valid_o (ld_valid),
    .out_ready_i (ld_ready),
    .out_neg_o   (ld_neg),
    .out_bcd_o   (ld_bcd),
    .out_nsig_o  (ld_nsig)
  );

  // Emit characters
  sidec_serializer #(
    .NumDigits (NumDigits),
    .IdxW      (IdxW)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ld_valid),
    .in_ready_o  (ld_ready),
    .in_neg_i    (ld_neg),
    .in_bcd_i    (ld_bcd),
    .in_nsig_i   (ld_nsig),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (char_code_o),
    .out_last_o  (last_o)
  );

endmodule

[test/signed_int_to_decimal_ascii_unit_tb.sv]
module signed_int_to_decimal_ascii_unit_tb;

  import sidec_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last;
  } ascii_char_t;

  localparam int unsigned ValueW      = 32;
  localparam int unsigned NumDirected = 20;
  localparam int unsigned NumRandom   = 100;
  localparam int unsigned NumQuiet    = 24;
  localparam int unsigned DrainCycles = 24;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [ValueW-1:0] value_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CharW-1:0]  char_code_o;
  logic              last_o;

  ascii_char_t expected_chars[$];
  int          error_count = 0;
  bit          quiet_phase = 1'b0;

  // Directed rows; a non-empty text is the known decimal string for that value
  logic [ValueW-1:0] dir_value [NumDirected] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h0000_0009, 32'h0000_000A, 32'hFFFF_FFF7, 32'hFFFF_FFF6, 32'h0000_0063,
    32'h0000_0064, 32'h3B9A_CA00, 32'h3B9A_C9FF, 32'hC465_3600, 32'h075B_CD15,
    32'hC521_974F, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFE, 32'h8000_0001
  };
  string dir_text [NumDirected] = '{
    "0", "1", "-1", "2147483647", "-2147483648",
    "", "", "", "", "", "", "", "", "", "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii_unit #(
    .VALUE_WIDTH(ValueW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Queue the decimal text of one value: sign, then digits most significant first
  function automatic void predict_text(input logic [ValueW-1:0] value);
    logic [ValueW-1:0] magnitude;
    logic [3:0]        digits[$];
    ascii_char_t       c;
    magnitude = value[ValueW-1] ? (~value + 1'b1) : value;
    do begin
      digits.push_front(4'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (value[ValueW-1]) begin
      c.char_code = CharMinus;
      c.last      = 1'b0;
      expected_chars.push_back(c);
    end
    foreach (digits[i]) begin
      c.char_code = CharZero + CharW'(digits[i]);
      c.last      = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Queue a known string as it stands
  function automatic void queue_text(input string text);
    ascii_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.char_code = CharW'(text[i]);
      c.last      = (i == text.len() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Offer one value, hold it until the transfer, then maybe idle for a burst
  task automatic send_value(input logic [ValueW-1:0] value, input string text);
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    if (text.len() != 0) queue_text(text);
    else predict_text(value);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Draw a value from one of several shapes that stress digit counts and extremes
  function automatic logic [ValueW-1:0] random_value();
    int unsigned       pow10 [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                      10000000, 100000000, 1000000000};
    logic [ValueW-1:0] value;
    case ($urandom_range(0, 4))
      0: value = $urandom;
      1: value = $urandom_range(0, 20);
      2: value = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
      3: value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                      : 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: value = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) != 0) value = -value;
    return value;
  endfunction

  // Check each character transfer and set the stall pattern for the next cycle
  initial begin
    int unsigned stall_left;
    ascii_char_t want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $error("char_code: no character expected, got %0d", char_code_o);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (char_code_o !== want.char_code) begin
            $error("char_code: expected %0d, got %0d", want.char_code, char_code_o);
            error_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            error_count++;
          end
        end
      end
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed table, random values, then drain
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) send_value(dir_value[i], dir_text[i]);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - NumQuiet) quiet_phase = 1'b1;
      send_value(random_value(), "");
    end
    in_valid_i <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASS signed_int_to_decimal_ascii_unit");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii_unit");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4000000;
    $display("FAIL signed_int_to_decimal_ascii_unit");
    $finish;
  end

endmodule
